>>> rtl/core/dual_reload_down_timer_defines.svh
// ----------------------------------------------------------------------------
// Dual reload down timer assertion macros
// Shared concurrent assertion helpers for the timer RTL.
// ----------------------------------------------------------------------------
`ifndef DUAL_RELOAD_DOWN_TIMER_DEFINES_SVH
`define DUAL_RELOAD_DOWN_TIMER_DEFINES_SVH

// Check a property on a given clock, off while the given reset is low
`define DRTIM_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset
`define DRTIM_ASSERT(lbl, prop, msg) `DRTIM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/drtim_pkg.sv
// ----------------------------------------------------------------------------
// Dual reload down timer package
// Request and response types, operation and register codes, field positions.
// ----------------------------------------------------------------------------
package drtim_pkg;

  // Width of the reload buffers and live counters
  localparam int unsigned CountWidth = 32;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned NumChan    = 2;

  // Operation codes
  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpWrite = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;
  localparam logic [1:0] OpNop   = 2'd3;

  // Register select codes
  localparam logic [2:0] RegCtrl   = 3'd0;
  localparam logic [2:0] RegPresc  = 3'd1;
  localparam logic [2:0] RegDiv    = 3'd2;
  localparam logic [2:0] RegIrq    = 3'd3;
  localparam logic [2:0] RegBuf0   = 3'd4;
  localparam logic [2:0] RegCnt0   = 3'd5;
  localparam logic [2:0] RegBuf4   = 3'd6;
  localparam logic [2:0] RegCnt4   = 3'd7;

  // Register widths
  localparam int unsigned PrescWidth = 16;
  localparam int unsigned DivWidth   = 20;
  localparam int unsigned IrqWidth   = 5;

  // Per-channel control and field positions (timer 0, timer 4)
  localparam int unsigned EnBit      [NumChan] = '{0, 20};
  localparam int unsigned ManBit     [NumChan] = '{1, 21};
  localparam int unsigned AutoBit    [NumChan] = '{3, 22};
  localparam int unsigned PrescShift [NumChan] = '{0, 8};
  localparam int unsigned DivShift   [NumChan] = '{0, 16};
  localparam int unsigned IrqPos     [NumChan] = '{0, 4};

  // Divider exponent saturates here
  localparam logic [3:0] DivMax = 4'd4;

  typedef struct packed {
    logic [1:0]           op;
    logic [2:0]           reg_sel;
    logic [DataWidth-1:0] write_data;
  } drtim_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 irq_timer0;
    logic                 irq_timer4;
  } drtim_rsp_t;

endpackage

>>> rtl/core/dual_reload_down_timer.sv
// ----------------------------------------------------------------------------
// Dual reload down timer
// Two-channel prescaled down counter with autoreload and interrupt status.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid_i / req_ready_o / req_i) carries one
//   operation per request: a timer tick, a register write or a register read.
//   The response channel (rsp_valid_o / rsp_ready_i / rsp_o) returns exactly
//   one response per request: read data (zero unless a read) and both timer
//   interrupt lines as seen after the request took effect.
//   The response is registered, valid in the cycle after its request. A request is taken in
//   every cycle, limited only by the single response register: while a
//   response is held and the receiver stalls, req_ready_o drops, and it rises
//   again in the cycle the response is taken.
//   All register, prescaler, divider, counter and halt state is applied in
//   the cycle a request is accepted, so back-to-back requests see each
//   other's effects in order.
//   Reset clears every register and counter, masks both interrupts and
//   leaves the response register empty.
// ----------------------------------------------------------------------------
`include "dual_reload_down_timer_defines.svh"

module dual_reload_down_timer
  import drtim_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  drtim_req_t req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output drtim_rsp_t rsp_o
);

  // Architectural state
  logic [DataWidth-1:0]  ctrl_q, ctrl_d;
  logic [PrescWidth-1:0] presc_q, presc_d;
  logic [DivWidth-1:0]   div_q, div_d;
  logic [IrqWidth-1:0]   irq_en_q, irq_en_d;
  logic [IrqWidth-1:0]   irq_sta_q, irq_sta_d;
  logic [CountWidth-1:0] buf_q   [NumChan];
  logic [CountWidth-1:0] buf_d   [NumChan];
  logic [CountWidth-1:0] count_q [NumChan];
  logic [CountWidth-1:0] count_d [NumChan];
  logic [7:0]            pcnt_q  [NumChan];
  logic [7:0]            pcnt_d  [NumChan];
  logic [3:0]            dcnt_q  [NumChan];
  logic [3:0]            dcnt_d  [NumChan];
  logic [NumChan-1:0]    halt_q, halt_d;

  // Response register
  logic       rsp_valid_q;
  drtim_rsp_t rsp_q, rsp_d;

  // Per-channel tick outcome
  logic [CountWidth-1:0] tk_count [NumChan];
  logic [7:0]            tk_pcnt  [NumChan];
  logic [3:0]            tk_dcnt  [NumChan];
  logic [NumChan-1:0]    tk_halt;
  logic [NumChan-1:0]    tk_zero;
  logic [IrqWidth-1:0]   tk_sta_set;

  logic req_accept;
  logic rsp_accept;

  // Take a request whenever the response slot is free or draining
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign req_accept  = req_valid_i && req_ready_o;
  assign rsp_accept  = rsp_valid_q && rsp_ready_i;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Advance prescaler, divider and counter of each channel on a tick
  for (genvar ch = 0; ch < NumChan; ch++) begin : g_chan
    logic       run;
    logic [7:0] limit;
    logic [3:0] div_raw;
    logic [2:0] div_sat;
    logic [4:0] dlimit;

    assign run     = ctrl_q[EnBit[ch]] && !halt_q[ch];
    assign limit   = presc_q[PrescShift[ch] +: 8];
    assign div_raw = div_q[DivShift[ch] +: 4];
    assign div_sat = (div_raw > DivMax) ? DivMax[2:0] : div_raw[2:0];
    assign dlimit  = (5'd1 << div_sat) - 5'd1;

    always_comb begin
      tk_count[ch] = count_q[ch];
      tk_pcnt[ch]  = pcnt_q[ch];
      tk_dcnt[ch]  = dcnt_q[ch];
      tk_halt[ch]  = halt_q[ch];
      tk_zero[ch]  = 1'b0;
      if (run) begin
        if (pcnt_q[ch] < limit) begin
          tk_pcnt[ch] = pcnt_q[ch] + 8'd1;
        end else begin
          tk_pcnt[ch] = 8'd0;
          if ({1'b0, dcnt_q[ch]} < dlimit) begin
            tk_dcnt[ch] = dcnt_q[ch] + 4'd1;
          end else begin
            tk_dcnt[ch] = 4'd0;
            // A counter already at zero signals at once
            if (count_q[ch] == '0) begin
              tk_zero[ch] = 1'b1;
            end else begin
              tk_count[ch] = count_q[ch] - CountWidth'(1);
              tk_zero[ch]  = (count_q[ch] == CountWidth'(1));
            end
            // Reload or halt on reaching zero
            if (tk_zero[ch]) begin
              if (ctrl_q[AutoBit[ch]]) begin
                tk_count[ch] = buf_q[ch];
              end else begin
                tk_halt[ch] = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  // Collect status bits raised by the tick
  always_comb begin
    tk_sta_set = '0;
    for (int ch = 0; ch < NumChan; ch++) begin
      tk_sta_set[IrqPos[ch]] = tk_zero[ch];
    end
  end

  // Apply the accepted request and form its response
  always_comb begin
    ctrl_d    = ctrl_q;
    presc_d   = presc_q;
    div_d     = div_q;
    irq_en_d  = irq_en_q;
    irq_sta_d = irq_sta_q;
    buf_d     = buf_q;
    count_d   = count_q;
    pcnt_d    = pcnt_q;
    dcnt_d    = dcnt_q;
    halt_d    = halt_q;
    rsp_d     = rsp_q;
    if (req_accept) begin
      rsp_d.read_data = '0;
      case (req_i.op)
        OpTick: begin
          count_d   = tk_count;
          pcnt_d    = tk_pcnt;
          dcnt_d    = tk_dcnt;
          halt_d    = tk_halt;
          irq_sta_d = irq_sta_q | tk_sta_set;
        end
        OpWrite: begin
          case (req_i.reg_sel)
            RegCtrl: begin
              ctrl_d = req_i.write_data;
              // Manual reload copies the buffer and restarts the channel
              for (int ch = 0; ch < NumChan; ch++) begin
                if (req_i.write_data[ManBit[ch]]) begin
                  count_d[ch] = buf_q[ch];
                  halt_d[ch]  = 1'b0;
                end
              end
            end
            RegPresc: presc_d = req_i.write_data[PrescWidth-1:0];
            RegDiv:   div_d   = req_i.write_data[DivWidth-1:0];
            RegIrq: begin
              irq_en_d  = req_i.write_data[IrqWidth-1:0];
              irq_sta_d = irq_sta_q & ~req_i.write_data[2*IrqWidth-1:IrqWidth];
            end
            RegBuf0:  buf_d[0] = req_i.write_data[CountWidth-1:0];
            RegBuf4:  buf_d[1] = req_i.write_data[CountWidth-1:0];
            default: ;  // live counts are read only
          endcase
        end
        OpRead: begin
          case (req_i.reg_sel)
            RegCtrl:  rsp_d.read_data = ctrl_q;
            RegPresc: rsp_d.read_data = DataWidth'(presc_q);
            RegDiv:   rsp_d.read_data = DataWidth'(div_q);
            RegIrq:   rsp_d.read_data = DataWidth'({irq_sta_q, irq_en_q});
            RegBuf0:  rsp_d.read_data = DataWidth'(buf_q[0]);
            RegCnt0:  rsp_d.read_data = DataWidth'(count_q[0]);
            RegBuf4:  rsp_d.read_data = DataWidth'(buf_q[1]);
            RegCnt4:  rsp_d.read_data = DataWidth'(count_q[1]);
            default:  rsp_d.read_data = '0;
          endcase
        end
        default: ;  // no operation
      endcase
      rsp_d.irq_timer0 = irq_sta_d[IrqPos[0]] && irq_en_d[IrqPos[0]];
      rsp_d.irq_timer4 = irq_sta_d[IrqPos[1]] && irq_en_d[IrqPos[1]];
    end
  end

  // Hold architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= '0;
      presc_q   <= '0;
      div_q     <= '0;
      irq_en_q  <= '0;
      irq_sta_q <= '0;
      halt_q    <= '0;
      for (int ch = 0; ch < NumChan; ch++) begin
        buf_q[ch]   <= '0;
        count_q[ch] <= '0;
        pcnt_q[ch]  <= '0;
        dcnt_q[ch]  <= '0;
      end
    end else begin
      ctrl_q    <= ctrl_d;
      presc_q   <= presc_d;
      div_q     <= div_d;
      irq_en_q  <= irq_en_d;
      irq_sta_q <= irq_sta_d;
      halt_q    <= halt_d;
      buf_q     <= buf_d;
      count_q   <= count_d;
      pcnt_q    <= pcnt_d;
      dcnt_q    <= dcnt_d;
    end
  end

  // Track response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_accept) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Load response payload
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  // Assertions
  `DRTIM_ASSERT(a_stall_blocks_req,
                rsp_valid_q && !rsp_ready_i |-> !req_ready_o,
                "request taken while response stalled")
  `DRTIM_ASSERT(a_irq0_matches_state,
                req_accept |=> rsp_o.irq_timer0 ==
                  (irq_sta_q[IrqPos[0]] && irq_en_q[IrqPos[0]]),
                "timer 0 irq does not match status and enable")
  `DRTIM_ASSERT(a_nonread_zero,
                req_accept && req_i.op != OpRead |=> rsp_o.read_data == '0,
                "read data nonzero on a non-read request")
  `DRTIM_ASSERT(a_halted_holds,
                req_accept && req_i.op == OpTick && halt_q[0] |=>
                  $stable(count_q[0]) && $stable(pcnt_q[0]),
                "halted timer 0 moved on a tick")

endmodule

>>> dv/tb_dual_reload_down_timer.sv
// ----------------------------------------------------------------------------
// Dual reload down timer testbench
// Drives ticks, register writes and register reads through the request
// channel with bursty gaps while the response side stalls in shifting
// patterns. Each accepted request runs through a behavioral timer model in
// the testbench, and every response is compared field by field against the
// oldest predicted response.
// ----------------------------------------------------------------------------
module tb_dual_reload_down_timer;
  import drtim_pkg::*;

  localparam int unsigned RandomItems = 2000;
  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 4;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyRandom,
    ReadyPeriodic
  } ready_mode_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       req_valid_i = 1'b0;
  logic       req_ready_o;
  drtim_req_t req_i       = '0;
  logic       rsp_valid_o;
  logic       rsp_ready_i = 1'b0;
  drtim_rsp_t rsp_o;

  // Request stream and predicted responses
  drtim_req_t timer_reqs[$];
  drtim_rsp_t awaited_rsp[$];
  drtim_rsp_t want_rsp;
  int unsigned stim_items = 0;
  int unsigned errors     = 0;
  int unsigned cycle_count = 0;

  // Timer model state
  logic [DataWidth-1:0]  ctrl_q     = '0;
  logic [PrescWidth-1:0] presc_q    = '0;
  logic [DivWidth-1:0]   div_q      = '0;
  logic [IrqWidth-1:0]   irq_en_q   = '0;
  logic [IrqWidth-1:0]   irq_stat_q = '0;
  logic [CountWidth-1:0] reload_q  [NumChan] = '{default: '0};
  logic [CountWidth-1:0] count_q   [NumChan] = '{default: '0};
  logic [7:0]            pre_cnt_q [NumChan] = '{default: '0};
  logic [3:0]            div_cnt_q [NumChan] = '{default: '0};
  logic                  halted_q  [NumChan] = '{default: 1'b0};
  int unsigned tick_reqs = 0;
  int unsigned write_reqs = 0;
  int unsigned read_reqs = 0;
  int unsigned expiries = 0;

  // Sender burst shaping and receiver stall pattern
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  ready_mode_e ready_mode = ReadyAlways;
  int unsigned mode_left  = 0;
  int unsigned stall_period = 2;
  int unsigned stall_phase  = 0;

  dual_reload_down_timer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Advance one channel by one timer tick
  function automatic void advance_channel(int ch);
    logic [7:0] pre_limit;
    logic [3:0] div_exp;
    logic [3:0] div_limit;
    if (!ctrl_q[EnBit[ch]] || halted_q[ch]) return;
    pre_limit = presc_q[PrescShift[ch] +: 8];
    if (pre_cnt_q[ch] < pre_limit) begin
      pre_cnt_q[ch] = pre_cnt_q[ch] + 8'd1;
      return;
    end
    pre_cnt_q[ch] = '0;
    div_exp = div_q[DivShift[ch] +: 4];
    if (div_exp > DivMax) div_exp = DivMax;
    div_limit = 4'((5'd1 << div_exp) - 5'd1);
    if (div_cnt_q[ch] < div_limit) begin
      div_cnt_q[ch] = div_cnt_q[ch] + 4'd1;
      return;
    end
    div_cnt_q[ch] = '0;
    // A counter already at zero expires at once, otherwise on reaching zero
    if (count_q[ch] != '0) count_q[ch] = count_q[ch] - 1'b1;
    if (count_q[ch] == '0) begin
      expiries++;
      irq_stat_q[IrqPos[ch]] = 1'b1;
      if (ctrl_q[AutoBit[ch]]) count_q[ch] = reload_q[ch];
      else halted_q[ch] = 1'b1;
    end
  endfunction

  // Apply one request to the timer model and return the response it yields
  function automatic drtim_rsp_t apply_timer_request(drtim_req_t r);
    drtim_rsp_t rsp;
    int ch;
    rsp = '0;
    case (r.op)
      OpTick: begin
        tick_reqs++;
        for (ch = 0; ch < NumChan; ch++) advance_channel(ch);
      end
      OpWrite: begin
        write_reqs++;
        case (r.reg_sel)
          RegCtrl: begin
            ctrl_q = r.write_data;
            for (ch = 0; ch < NumChan; ch++) begin
              if (r.write_data[ManBit[ch]]) begin
                count_q[ch]  = reload_q[ch];
                halted_q[ch] = 1'b0;
              end
            end
          end
          RegPresc: presc_q = r.write_data[PrescWidth-1:0];
          RegDiv:   div_q   = r.write_data[DivWidth-1:0];
          RegIrq: begin
            irq_en_q   = r.write_data[IrqWidth-1:0];
            irq_stat_q = irq_stat_q & ~r.write_data[2*IrqWidth-1:IrqWidth];
          end
          RegBuf0: reload_q[0] = r.write_data[CountWidth-1:0];
          RegBuf4: reload_q[1] = r.write_data[CountWidth-1:0];
          default: ;
        endcase
      end
      OpRead: begin
        read_reqs++;
        case (r.reg_sel)
          RegCtrl:  rsp.read_data = ctrl_q;
          RegPresc: rsp.read_data = DataWidth'(presc_q);
          RegDiv:   rsp.read_data = DataWidth'(div_q);
          RegIrq:   rsp.read_data = DataWidth'({irq_stat_q, irq_en_q});
          RegBuf0:  rsp.read_data = DataWidth'(reload_q[0]);
          RegCnt0:  rsp.read_data = DataWidth'(count_q[0]);
          RegBuf4:  rsp.read_data = DataWidth'(reload_q[1]);
          default:  rsp.read_data = DataWidth'(count_q[1]);
        endcase
      end
      default: ;
    endcase
    rsp.irq_timer0 = irq_stat_q[IrqPos[0]] & irq_en_q[IrqPos[0]];
    rsp.irq_timer4 = irq_stat_q[IrqPos[1]] & irq_en_q[IrqPos[1]];
    return rsp;
  endfunction

  // Queue one request; nops and writes to the live counts do not count
  function automatic void queue_req(logic [1:0] op, logic [2:0] sel, logic [31:0] data);
    drtim_req_t r;
    r.op         = op;
    r.reg_sel    = sel;
    r.write_data = data;
    timer_reqs.push_back(r);
    if (op != OpNop && !(op == OpWrite && (sel == RegCnt0 || sel == RegCnt4)))
      stim_items++;
  endfunction

  // Drive requests in bursts separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else if (!req_valid_i || req_ready_o) begin
      if (gap_left > 0) begin
        req_valid_i <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (timer_reqs.size() > 0) begin
        req_valid_i <= 1'b1;
        req_i       <= timer_reqs.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  // Stall the response side in a pattern that changes every so often
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode   <= ready_mode_e'($urandom_range(0, 2));
        mode_left    <= $urandom_range(20, 120);
        stall_period <= $urandom_range(2, 5);
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_phase <= (stall_phase + 1 >= stall_period) ? 0 : stall_phase + 1;
      case (ready_mode)
        ReadyAlways: rsp_ready_i <= 1'b1;
        ReadyRandom: rsp_ready_i <= ($urandom_range(0, 9) > 2);
        default:     rsp_ready_i <= (stall_phase == 0);
      endcase
    end
  end

  // Check each accepted response, then predict for each accepted request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: unexpected response: expected none, actual %h", $time, rsp_o);
          errors++;
        end else begin
          want_rsp = awaited_rsp.pop_front();
          if (rsp_o.read_data !== want_rsp.read_data) begin
            $display("%0t: read_data mismatch: expected %h, actual %h",
                     $time, want_rsp.read_data, rsp_o.read_data);
            errors++;
          end
          if (rsp_o.irq_timer0 !== want_rsp.irq_timer0) begin
            $display("%0t: irq_timer0 mismatch: expected %b, actual %b",
                     $time, want_rsp.irq_timer0, rsp_o.irq_timer0);
            errors++;
          end
          if (rsp_o.irq_timer4 !== want_rsp.irq_timer4) begin
            $display("%0t: irq_timer4 mismatch: expected %b, actual %b",
                     $time, want_rsp.irq_timer4, rsp_o.irq_timer4);
            errors++;
          end
        end
      end
      if (req_valid_i && req_ready_o) awaited_rsp.push_back(apply_timer_request(req_i));
    end
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, awaited_rsp.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int ch;
    int k;
    int n_steps;
    int pick;
    logic [31:0] word;

    // Directed: register extremes, zero-count expiry, saturation, limit drops
    queue_req(OpRead,  RegCtrl, 32'h0);
    queue_req(OpWrite, RegBuf0, 32'hFFFF_FFFF);
    queue_req(OpWrite, RegBuf4, 32'h0);
    queue_req(OpWrite, RegIrq,  32'h0000_001F);
    queue_req(OpWrite, RegCtrl, (32'd1 << EnBit[0]) | (32'd1 << ManBit[0]) |
                                (32'd1 << EnBit[1]) | (32'd1 << ManBit[1]));
    queue_req(OpTick,  RegCtrl, 32'h0);
    queue_req(OpTick,  RegCtrl, 32'hFFFF_FFFF);
    queue_req(OpRead,  RegIrq,  32'h0);
    queue_req(OpRead,  RegCnt0, 32'h0);
    queue_req(OpWrite, RegCnt0, 32'h1234_5678);
    queue_req(OpRead,  RegCnt0, 32'h0);
    queue_req(OpWrite, RegPresc, 32'hFFFF_FFFF);
    queue_req(OpWrite, RegDiv,  32'hFFFF_FFFF);
    for (k = 0; k < 3; k++) queue_req(OpTick, RegCtrl, 32'h0);
    queue_req(OpWrite, RegPresc, 32'h0);
    queue_req(OpTick,  RegCtrl, 32'h0);
    queue_req(OpRead,  RegDiv,  32'h0);
    queue_req(OpWrite, RegIrq,  32'hFFFF_FFE0);
    queue_req(OpWrite, RegBuf0, 32'h1);
    queue_req(OpWrite, RegDiv,  32'h0);
    queue_req(OpWrite, RegCtrl, (32'd1 << EnBit[0]) | (32'd1 << ManBit[0]) |
                                (32'd1 << AutoBit[0]));
    queue_req(OpTick,  RegCtrl, 32'h0);
    queue_req(OpTick,  RegCtrl, 32'h0);
    queue_req(OpNop,   RegCnt4, 32'hFFFF_FFFF);
    queue_req(OpWrite, RegCtrl, 32'hFFFF_FFFF);
    queue_req(OpRead,  RegCtrl, 32'h0);

    // Random: mostly programmed runs of ticks, with some raw noise
    while (stim_items < RandomItems) begin
      if ($urandom_range(0, 9) < 7) begin
        ch = $urandom_range(0, 1);
        queue_req(OpWrite, ch ? RegBuf4 : RegBuf0,
                  ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 6));
        word = $urandom;
        for (k = 0; k < NumChan; k++)
          word[PrescShift[k] +: 8] = 8'(($urandom_range(0, 7) == 0) ?
                                        $urandom_range(0, 255) : $urandom_range(0, 3));
        queue_req(OpWrite, RegPresc, word);
        word = $urandom;
        for (k = 0; k < NumChan; k++)
          word[DivShift[k] +: 4] = 4'(($urandom_range(0, 5) == 0) ?
                                      $urandom_range(0, 15) : $urandom_range(0, 2));
        queue_req(OpWrite, RegDiv, word);
        queue_req(OpWrite, RegIrq, $urandom);
        word = $urandom;
        for (k = 0; k < NumChan; k++) begin
          word[EnBit[k]]   = ($urandom_range(0, 4) != 0);
          word[ManBit[k]]  = ($urandom_range(0, 2) != 0);
          word[AutoBit[k]] = 1'($urandom_range(0, 1));
        end
        queue_req(OpWrite, RegCtrl, word);
        n_steps = $urandom_range(1, 48);
        for (k = 0; k < n_steps; k++) begin
          pick = $urandom_range(0, 15);
          case (pick)
            0: queue_req(OpRead, 3'($urandom_range(0, 7)), $urandom);
            1: queue_req(OpWrite, RegIrq, $urandom);
            2: queue_req(OpWrite, RegPresc, $urandom_range(0, 16'h0303));
            3: queue_req(OpWrite, RegCtrl, word | (32'd1 << ManBit[ch]));
            default: queue_req(OpTick, 3'($urandom_range(0, 7)), $urandom);
          endcase
        end
        queue_req(OpRead, RegCnt0, $urandom);
        queue_req(OpRead, RegCnt4, $urandom);
        queue_req(OpRead, RegIrq,  $urandom);
      end else begin
        n_steps = $urandom_range(1, 8);
        for (k = 0; k < n_steps; k++)
          queue_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain the request stream, then the outstanding responses
    while (timer_reqs.size() != 0 || req_valid_i) @(posedge clk_i);
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d ticks, %0d register writes and %0d register reads in %0d cycles",
             tick_reqs, write_reqs, read_reqs, cycle_count);
    $display("Model saw %0d counter expiries; %0d mismatches", expiries, errors);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/drtim_pkg.sv
rtl/core/dual_reload_down_timer.sv
dv/tb_dual_reload_down_timer.sv
